// ----- design/exdt_pkg.sv -----
// Shared types, constants and a lookup function for the EXIF date-time converter.
package exdt_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned DaysW   = 22;
  localparam int unsigned DaysSumW = 23;
  localparam int unsigned HmsW    = 17;
  localparam int unsigned SecsW   = 39;
  localparam int unsigned MillisW = 48;

  // Character positions inside "yyyy:MM:dd HH:mm:ss"
  localparam logic [PosW-1:0] PosColonYm = 5'd4;
  localparam logic [PosW-1:0] PosColonMd = 5'd7;
  localparam logic [PosW-1:0] PosSpace   = 5'd10;
  localparam logic [PosW-1:0] PosColonHm = 5'd13;
  localparam logic [PosW-1:0] PosColonMs = 5'd16;
  localparam logic [PosW-1:0] DtLen      = 5'd19;

  localparam logic [CharW-1:0] CharColon = 8'h3A;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  localparam logic [YearW-1:0]  EpochYear = 14'd1970;
  localparam logic [FieldW-1:0] MonthMax  = 7'd12;
  localparam logic [FieldW-1:0] DayMax    = 7'd31;
  localparam logic [FieldW-1:0] HourMax   = 7'd23;
  localparam logic [FieldW-1:0] MinuteMax = 7'd59;
  localparam logic [FieldW-1:0] SecondMax = 7'd60;
  localparam logic [FieldW-1:0] MonthFeb  = 7'd2;

  // Day number of 1970-01-01 in the March-based civil count, plus one for day-1
  localparam logic [DaysSumW-1:0] EpochDayBias = 23'd719469;
  // floor(x/25) == (x * Recip25) >> Recip25Shift for x below 43690
  localparam logic [12:0] Recip25      = 13'd5243;
  localparam int unsigned Recip25Shift = 17;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LAYOUT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             final_byte;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [MillisW-1:0] epoch_millis;
  } out_item_t;

  // Days from March 1 to the first of the month, year starting in March
  function automatic logic [DoyW-1:0] month_offset(input logic [FieldW-1:0] month);
    logic [DoyW-1:0] ofs;
    unique case (month)
      7'd3:    ofs = 9'd0;
      7'd4:    ofs = 9'd31;
      7'd5:    ofs = 9'd61;
      7'd6:    ofs = 9'd92;
      7'd7:    ofs = 9'd122;
      7'd8:    ofs = 9'd153;
      7'd9:    ofs = 9'd184;
      7'd10:   ofs = 9'd214;
      7'd11:   ofs = 9'd245;
      7'd12:   ofs = 9'd275;
      7'd1:    ofs = 9'd306;
      7'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ----- design/exdt_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per transaction.
interface exdt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/exif_datetime_to_epoch_millis_top.sv -----
// Top level: streaming EXIF date-time parser and epoch-milliseconds converter.
//
//  channel | dir | payload                              | transaction
//  --------+-----+--------------------------------------+--------------------------------
//  in_i    | in  | char_byte[7:0], final_byte           | one character of the string
//  out_o   | out | status[1:0], epoch_millis[47:0]      | one result per final character
//
//  A new character can be accepted every cycle while in_i.ready is high.
//  A final character's result reaches out_o through five registers: parse register,
//  calendar terms, day sum, seconds multiply (22x17 bits), millis shift-add register.
//  Each stage moves when the one after it is empty or moving, so bubbles collapse and
//  in_i.ready falls only when all five stages hold results and out_o is stalled.
//  Reset clears the parse state and all stage valid bits; no clearing pass is needed.
module exif_datetime_to_epoch_millis_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  exdt_stream_if.sink         in_i,
  exdt_stream_if.source       out_o
);
  import exdt_pkg::*;

  // ---------------------------------------------------------------------------
  // Parse state: position, field accumulators, layout flag
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]   pos_q, pos_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [FieldW-1:0] month_q, month_d;
  logic [FieldW-1:0] day_q, day_d;
  logic [FieldW-1:0] hour_q, hour_d;
  logic [FieldW-1:0] minute_q, minute_d;
  logic [FieldW-1:0] second_q, second_d;
  logic              layout_err_q, layout_err_d;

  logic [CharW-1:0]  chr;
  logic              is_digit;
  logic [3:0]        digit;
  logic              in_fire;
  logic              in_last;

  assign chr      = in_i.payload.char_byte;
  assign is_digit = (chr >= CharZero) && (chr <= CharNine);
  assign digit    = chr[3:0];
  assign in_fire  = in_i.valid && in_i.ready;
  assign in_last  = in_i.payload.final_byte;

  // Check the character against the layout and push digits into their field.
  always_comb begin
    pos_d        = pos_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    layout_err_d = layout_err_q;
    // Characters past the last layout position are dropped.
    if (pos_q < DtLen) begin
      pos_d = pos_q + 5'd1;
      priority if (pos_q == PosColonYm || pos_q == PosColonMd ||
                   pos_q == PosColonHm || pos_q == PosColonMs) begin
        if (chr != CharColon) layout_err_d = 1'b1;
      end else if (pos_q == PosSpace) begin
        if (chr != CharSpace) layout_err_d = 1'b1;
      end else if (!is_digit) begin
        layout_err_d = 1'b1;
      end else if (pos_q < PosColonYm) begin
        year_d = YearW'(year_q * 14'd10 + YearW'(digit));
      end else if (pos_q < PosColonMd) begin
        month_d = FieldW'(month_q * 7'd10 + FieldW'(digit));
      end else if (pos_q < PosSpace) begin
        day_d = FieldW'(day_q * 7'd10 + FieldW'(digit));
      end else if (pos_q < PosColonHm) begin
        hour_d = FieldW'(hour_q * 7'd10 + FieldW'(digit));
      end else if (pos_q < PosColonMs) begin
        minute_d = FieldW'(minute_q * 7'd10 + FieldW'(digit));
      end else begin
        second_d = FieldW'(second_q * 7'd10 + FieldW'(digit));
      end
    end
  end

  // Advance on every accepted character; the final one starts a fresh string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      year_q       <= '0;
      month_q      <= '0;
      day_q        <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      layout_err_q <= 1'b0;
    end else if (in_fire) begin
      if (in_last) begin
        pos_q        <= '0;
        year_q       <= '0;
        month_q      <= '0;
        day_q        <= '0;
        hour_q       <= '0;
        minute_q     <= '0;
        second_q     <= '0;
        layout_err_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        year_q       <= year_d;
        month_q      <= month_d;
        day_q        <= day_d;
        hour_q       <= hour_d;
        minute_q     <= minute_d;
        second_q     <= second_d;
        layout_err_q <= layout_err_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage takes new data when empty or draining
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  assign rdy_out    = !out_v_q || out_o.ready;
  assign rdy4       = !s4_v_q || rdy_out;
  assign rdy3       = !s3_v_q || rdy4;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    s1_v_q  <= in_fire && in_last;
      if (rdy2)    s2_v_q  <= s1_v_q;
      if (rdy3)    s3_v_q  <= s2_v_q;
      if (rdy4)    s4_v_q  <= s3_v_q;
      if (rdy_out) out_v_q <= s4_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: completed fields of the string, including its final character
  // ---------------------------------------------------------------------------
  logic [YearW-1:0]  s1_year_q;
  logic [FieldW-1:0] s1_month_q, s1_day_q, s1_hour_q, s1_minute_q, s1_second_q;
  logic              s1_bad_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_fire && in_last) begin
      s1_year_q   <= year_d;
      s1_month_q  <= month_d;
      s1_day_q    <= day_d;
      s1_hour_q   <= hour_d;
      s1_minute_q <= minute_d;
      s1_second_q <= second_d;
      // A short string counts as a layout failure.
      s1_bad_q    <= layout_err_d || (pos_d < DtLen);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: status, March-based year terms, month offset
  // ---------------------------------------------------------------------------
  status_e            s1_status;
  logic [YearW-1:0]   s1_yy;
  logic [11:0]        s1_yy_div4;
  logic [9:0]         s1_yy_div16;
  logic [24:0]        s1_prod100;
  logic [22:0]        s1_prod400;
  logic               s1_range_bad;

  assign s1_range_bad = (s1_year_q < EpochYear) || (s1_month_q < 7'd1) ||
                        (s1_month_q > MonthMax) || (s1_day_q < 7'd1) ||
                        (s1_day_q > DayMax) || (s1_hour_q > HourMax) ||
                        (s1_minute_q > MinuteMax) || (s1_second_q > SecondMax);

  always_comb begin
    priority if (s1_bad_q)     s1_status = ST_LAYOUT;
    else if (s1_range_bad)     s1_status = ST_RANGE;
    else                       s1_status = ST_OK;
  end

  // January and February belong to the previous March-based year.
  assign s1_yy       = (s1_month_q <= MonthFeb) ? s1_year_q - 14'd1 : s1_year_q;
  assign s1_yy_div4  = s1_yy[YearW-1:2];
  assign s1_yy_div16 = s1_yy[YearW-1:4];
  assign s1_prod100  = s1_yy_div4 * Recip25;
  assign s1_prod400  = s1_yy_div16 * Recip25;

  status_e              s2_status_q;
  logic [DaysSumW-1:0]  s2_y365_q;
  logic [11:0]          s2_div4_q;
  logic [6:0]           s2_div100_q;
  logic [4:0]           s2_div400_q;
  logic [DoyW-1:0]      s2_doy_q;
  logic [FieldW-1:0]    s2_day_q, s2_hour_q, s2_minute_q, s2_second_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      s2_status_q <= s1_status;
      s2_y365_q   <= DaysSumW'(s1_yy * 23'd365);
      s2_div4_q   <= s1_yy_div4;
      s2_div100_q <= 7'(s1_prod100[24:Recip25Shift]);
      s2_div400_q <= 5'(s1_prod400[22:Recip25Shift]);
      s2_doy_q    <= month_offset(s1_month_q);
      s2_day_q    <= s1_day_q;
      s2_hour_q   <= s1_hour_q;
      s2_minute_q <= s1_minute_q;
      s2_second_q <= s1_second_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: day count since the epoch, seconds within the day
  // ---------------------------------------------------------------------------
  logic [DaysSumW-1:0] s2_days_sum;
  logic [HmsW-1:0]     s2_hms;

  assign s2_days_sum = s2_y365_q + DaysSumW'(s2_div4_q) - DaysSumW'(s2_div100_q) +
                       DaysSumW'(s2_div400_q) + DaysSumW'(s2_doy_q) +
                       DaysSumW'(s2_day_q) - EpochDayBias;
  assign s2_hms = HmsW'(s2_hour_q * 17'd3600) + HmsW'(s2_minute_q * 17'd60) +
                  HmsW'(s2_second_q);

  status_e          s3_status_q;
  logic [DaysW-1:0] s3_days_q;
  logic [HmsW-1:0]  s3_hms_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      s3_status_q <= s2_status_q;
      s3_days_q   <= s2_days_sum[DaysW-1:0];
      s3_hms_q    <= s2_hms;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: seconds since the epoch
  // ---------------------------------------------------------------------------
  status_e          s4_status_q;
  logic [SecsW-1:0] s4_secs_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_v_q) begin
      s4_status_q <= s3_status_q;
      // Widen the day count first so the product keeps all of its bits
      s4_secs_q   <= SecsW'(s3_days_q) * 17'd86400 + SecsW'(s3_hms_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: millis = secs * 1000 as (secs << 10) - (secs << 4) - (secs << 3)
  // ---------------------------------------------------------------------------
  logic [MillisW-1:0] s4_secs_ext;
  logic [MillisW-1:0] s4_millis;
  out_item_t          out_q;

  assign s4_secs_ext = MillisW'(s4_secs_q);
  assign s4_millis   = (s4_secs_ext << 10) - (s4_secs_ext << 4) - (s4_secs_ext << 3);

  always_ff @(posedge clk_i) begin
    if (rdy_out && s4_v_q) begin
      out_q.status       <= s4_status_q;
      out_q.epoch_millis <= (s4_status_q == ST_OK) ? s4_millis : '0;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

`ifndef NO_ASSERTIONS
  // A final character always lands in the parse register.
  a_final_loads_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last |=> s1_v_q)
    else $error("final character did not enter stage 1");

  // The final character returns the parser to the start of a string.
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last |=> pos_q == '0 && !layout_err_q && year_q == '0)
    else $error("parse state not cleared after final character");

  // Position saturates at the layout length.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= DtLen)
    else $error("character position beyond layout length");

  // Input backpressure only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_v_q && s2_v_q && s3_v_q && s4_v_q && out_v_q && !out_o.ready)
    else $error("input stalled with room in the pipeline");

  // A failing string never carries a time value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.status != ST_OK |-> out_o.payload.epoch_millis == '0)
    else $error("nonzero millis on a failing result");
`endif

endmodule

// ----- tb/tb_exif_datetime_to_epoch_millis_top.sv -----
// Testbench for the streaming EXIF date-time to epoch-milliseconds converter.
module tb_exif_datetime_to_epoch_millis_top;
  import exdt_pkg::*;

  typedef logic [CharW-1:0] char_t;
  typedef char_t            char_q_t[$];

  // Stall budget: cycles in a row with no transaction on either channel
  localparam int unsigned StallLimit  = 5000;
  // Pipeline depth is five stages; allow a few spare cycles after the drain
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxReports  = 20;

  logic clk;
  logic rst_n;

  exdt_stream_if #(.payload_t(in_item_t))  in_if ();
  exdt_stream_if #(.payload_t(out_item_t)) out_if ();

  exif_datetime_to_epoch_millis_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Handshake pressure knobs, percent of cycles
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // Shadow copy of the parse state
  logic [PosW-1:0]   stamp_pos;
  logic [YearW-1:0]  stamp_year;
  logic [FieldW-1:0] stamp_month;
  logic [FieldW-1:0] stamp_day;
  logic [FieldW-1:0] stamp_hour;
  logic [FieldW-1:0] stamp_minute;
  logic [FieldW-1:0] stamp_second;
  logic              stamp_bad;

  // Conversions predicted but not yet seen on out_o, oldest first
  out_item_t pending_conversions[$];

  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned strings_sent;
  int unsigned chars_sent;
  int unsigned results_checked;
  int unsigned ok_count;
  int unsigned layout_count;
  int unsigned range_count;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar prediction
  // --------------------------------------------------------------------------

  // Days from 1970-01-01 to the first of month m in year y (proleptic Gregorian),
  // counted in a March-based year so the leap day falls at the end.
  function automatic longint unsigned days_to_first_of_month(longint unsigned y,
                                                             longint unsigned m);
    longint unsigned yr;
    longint unsigned era;
    longint unsigned yoe;
    longint unsigned mar_month;
    longint unsigned doy;
    longint unsigned doe;
    yr        = (m <= 2) ? y - 1 : y;
    era       = yr / 400;
    yoe       = yr - era * 400;
    mar_month = (m > 2) ? m - 3 : m + 9;
    doy       = (153 * mar_month + 2) / 5;
    doe       = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Track one accepted character; on a final one, queue the expected conversion
  // and return the shadow parse state to reset.
  task automatic predict_stamp_char(input char_t c, input logic fin);
    logic            is_digit;
    logic [3:0]      digit;
    out_item_t       conv;
    longint unsigned days;
    longint unsigned secs;
    is_digit = (c >= CharZero) && (c <= CharNine);
    digit    = 4'(c - CharZero);
    // Drop anything past the fixed-length layout
    if (stamp_pos < DtLen) begin
      if (stamp_pos == PosColonYm || stamp_pos == PosColonMd ||
          stamp_pos == PosColonHm || stamp_pos == PosColonMs) begin
        if (c != CharColon) stamp_bad = 1'b1;
      end else if (stamp_pos == PosSpace) begin
        if (c != CharSpace) stamp_bad = 1'b1;
      end else if (!is_digit) begin
        stamp_bad = 1'b1;
      end else if (stamp_pos < PosColonYm) begin
        stamp_year = YearW'(stamp_year * 10 + digit);
      end else if (stamp_pos < PosColonMd) begin
        stamp_month = FieldW'(stamp_month * 10 + digit);
      end else if (stamp_pos < PosSpace) begin
        stamp_day = FieldW'(stamp_day * 10 + digit);
      end else if (stamp_pos < PosColonHm) begin
        stamp_hour = FieldW'(stamp_hour * 10 + digit);
      end else if (stamp_pos < PosColonMs) begin
        stamp_minute = FieldW'(stamp_minute * 10 + digit);
      end else begin
        stamp_second = FieldW'(stamp_second * 10 + digit);
      end
      stamp_pos = stamp_pos + 1'b1;
    end
    if (fin) begin
      conv.epoch_millis = '0;
      if (stamp_pos < DtLen || stamp_bad) begin
        conv.status = ST_LAYOUT;
        layout_count++;
      end else if (stamp_year < EpochYear || stamp_month < 1 || stamp_month > MonthMax ||
                   stamp_day < 1 || stamp_day > DayMax || stamp_hour > HourMax ||
                   stamp_minute > MinuteMax || stamp_second > SecondMax) begin
        conv.status = ST_RANGE;
        range_count++;
      end else begin
        // Day overflow and second 60 roll over naturally in the linear sum
        days = days_to_first_of_month(stamp_year, stamp_month) + stamp_day - 1;
        secs = days * 86400 + stamp_hour * 3600 + stamp_minute * 60 + stamp_second;
        conv.epoch_millis = MillisW'(secs * 1000);
        conv.status       = ST_OK;
        ok_count++;
      end
      pending_conversions.push_back(conv);
      strings_sent++;
      stamp_pos    = '0;
      stamp_year   = '0;
      stamp_month  = '0;
      stamp_day    = '0;
      stamp_hour   = '0;
      stamp_minute = '0;
      stamp_second = '0;
      stamp_bad    = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: every call starts and ends at a rising edge
  // --------------------------------------------------------------------------
  task automatic send_char(input char_t c, input logic fin);
    in_item_t item;
    // Idle the source for a random number of cycles
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    item.char_byte  = c;
    item.final_byte = fin;
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    // Ready settles between edges; check it mid-cycle, accept on the next edge
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    predict_stamp_char(c, fin);
  endtask

  // Send a whole string, flagging its last character as final
  task automatic send_stamp(input char_q_t chars);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  function automatic char_q_t to_chars(input string text);
    char_q_t chars;
    for (int i = 0; i < text.len(); i++) chars.push_back(char_t'(text[i]));
    return chars;
  endfunction

  function automatic char_q_t format_stamp(int y, int mo, int d, int h, int mi, int s);
    return to_chars($sformatf("%04d:%02d:%02d %02d:%02d:%02d", y, mo, d, h, mi, s));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall out_o at random, one assignment per edge
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: sample both channels mid-cycle, where every signal is stable; a
  // transaction seen here completes at the next rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : check_conversions
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (pending_conversions.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: unexpected result: status %0d, epoch_millis %0d",
                     $time, got.status, got.epoch_millis);
          end
        end else begin
          want = pending_conversions.pop_front();
          results_checked++;
          if (got.status !== want.status) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("%0t: status mismatch: expected %0d, actual %0d",
                       $time, want.status, got.status);
            end
          end
          if (got.epoch_millis !== want.epoch_millis) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("%0t: epoch_millis mismatch: expected %0d, actual %0d",
                       $time, want.epoch_millis, got.epoch_millis);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run if both channels sit still for too long
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("%0t: watchdog expired with %0d results outstanding",
             $time, pending_conversions.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Cover the epoch itself, the top of the range, leap day and both rollovers
  task automatic test_valid_extremes();
    send_stamp(to_chars("1970:01:01 00:00:00"));
    send_stamp(to_chars("9999:12:31 23:59:60"));
    send_stamp(to_chars("2024:02:29 12:34:56"));
    // Day past the end of February rolls into March
    send_stamp(to_chars("2023:02:31 00:00:00"));
    // Leap second on New Year's Eve rolls into the next year
    send_stamp(to_chars("2000:12:31 23:59:60"));
  endtask

  // Drive each field just outside its legal range, then every field far outside it
  task automatic test_range_checks();
    send_stamp(to_chars("1969:12:31 23:59:59"));
    send_stamp(to_chars("2021:00:10 10:10:10"));
    send_stamp(to_chars("2021:13:10 10:10:10"));
    send_stamp(to_chars("2021:05:00 10:10:10"));
    send_stamp(to_chars("2021:05:32 10:10:10"));
    send_stamp(to_chars("2021:05:10 24:10:10"));
    send_stamp(to_chars("2021:05:10 10:60:10"));
    send_stamp(to_chars("2021:05:10 10:10:61"));
    send_stamp(to_chars("0000:99:99 99:99:99"));
  endtask

  // Break the layout at a separator, at the space and at a digit position
  task automatic test_layout_checks();
    char_q_t chars;
    send_stamp(to_chars("2021-01-01 00:00:00"));
    send_stamp(to_chars("2021:01:01T00:00:00"));
    send_stamp(to_chars("20a1:01:01 00:00:00"));
    // All-ones and all-zeros bytes in digit positions
    chars     = to_chars("2021:01:01 00:00:00");
    chars[5]  = 8'hFF;
    chars[18] = 8'h00;
    send_stamp(chars);
  endtask

  // Short strings, a one-byte string, and trailing bytes that must be ignored
  task automatic test_length_handling();
    char_q_t chars;
    send_stamp(to_chars("2021:01:01"));
    send_stamp(to_chars("7"));
    chars = to_chars("2021:06:15 08:30:00");
    chars.push_back(8'hFF);
    chars.push_back(8'h00);
    chars.push_back(char_t'("x"));
    send_stamp(chars);
    send_stamp(to_chars("2021:06:15 08:30:00::::::"));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly well-formed strings, the rest broken or noise
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned char_budget);
    char_q_t     chars;
    int unsigned pick;
    int unsigned counted;
    int unsigned len;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    counted       = 0;
    while (counted < char_budget) begin
      pick = $urandom_range(99);
      if (pick < 70 || pick >= 80) begin
        chars = format_stamp($urandom_range(9999, 1970), $urandom_range(12, 1),
                             $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                             $urandom_range(60));
      end
      if (pick >= 60 && pick < 70) begin
        // Unconstrained digits: mostly range failures
        chars = format_stamp($urandom_range(9999), $urandom_range(99), $urandom_range(99),
                             $urandom_range(99), $urandom_range(99), $urandom_range(99));
      end else if (pick >= 70 && pick < 80) begin
        // One corrupted byte anywhere in the layout
        chars = format_stamp($urandom_range(9999, 1970), $urandom_range(12, 1),
                             $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                             $urandom_range(60));
        chars[$urandom_range(DtLen - 1)] = char_t'($urandom_range(255));
      end else if (pick >= 80 && pick < 88) begin
        // Truncate before the last field is complete
        len   = $urandom_range(DtLen - 1, 1);
        chars = chars[0:len-1];
      end else if (pick >= 88 && pick < 96) begin
        // Append trailing bytes that the block must skip
        repeat ($urandom_range(8, 1)) chars.push_back(char_t'($urandom_range(255)));
      end else if (pick >= 96) begin
        chars.delete();
        repeat ($urandom_range(25, 1)) chars.push_back(char_t'($urandom_range(255)));
      end
      send_stamp(chars);
      // Count only characters the block actually parses
      counted    += (chars.size() < DtLen) ? chars.size() : DtLen;
      chars_sent += (chars.size() < DtLen) ? chars.size() : DtLen;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    error_count     = 0;
    strings_sent    = 0;
    chars_sent      = 0;
    results_checked = 0;
    ok_count        = 0;
    layout_count    = 0;
    range_count     = 0;
    stamp_pos    = '0;
    stamp_year   = '0;
    stamp_month  = '0;
    stamp_day    = '0;
    stamp_hour   = '0;
    stamp_minute = '0;
    stamp_second = '0;
    stamp_bad    = 1'b0;

    // Assert reset once
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs back to back with no idling
    test_valid_extremes();
    test_range_checks();
    test_layout_checks();
    test_length_handling();

    // Random part across the four pressure phases
    test_random_traffic(0, 0, 400);
    test_random_traffic(87, 0, 400);
    test_random_traffic(0, 87, 400);
    test_random_traffic(32, 32, 400);

    // Release the input channel, drain, then let the pipeline settle
    in_if.valid   <= 1'b0;
    snk_stall_pct = 0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d strings (%0d parsed random characters); checked %0d results",
             strings_sent, chars_sent, results_checked);
    $display("Outcomes: %0d converted, %0d layout or length errors, %0d range errors",
             ok_count, layout_count, range_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/exdt_pkg.sv
design/exdt_stream_if.sv
design/exif_datetime_to_epoch_millis_top.sv
tb/tb_exif_datetime_to_epoch_millis_top.sv
